// ----- hdl/escape_sequence_decoder_core_assert.svh -----
// Assertion macros shared by the escape sequence decoder checker.
`ifndef ESCAPE_SEQUENCE_DECODER_CORE_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ESD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- hdl/esd_pkg.sv -----
// Shared types and constants of the escape sequence decoder.
package esd_pkg;

    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned CNT_W       = 2;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_INTERPRET = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_NEWLINE   = 3'd4;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_OCT   = 2'd2;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_ONE       = 8'h31;
    localparam logic [7:0] CH_TWO       = 8'h32;
    localparam logic [7:0] CH_THREE     = 8'h33;
    localparam logic [7:0] CH_FOUR      = 8'h34;
    localparam logic [7:0] CH_FIVE      = 8'h35;
    localparam logic [7:0] CH_SIX       = 8'h36;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_C         = 8'h63;
    localparam logic [7:0] CH_E         = 8'h65;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_V         = 8'h76;

    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_VT  = 8'h0B;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_ESC = 8'h1B;

    typedef struct packed {
        logic [CNT_W-1:0]            cnt;
        logic [MAX_RESULTS-1:0][7:0] bytes;
    } bundle_t;

endpackage

// ----- hdl/esd_front.sv -----
// Front end: accepts input transactions, decodes escapes and builds result bundles.
module esd_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       text_byte,
    input  logic             has_byte,
    input  logic             end_of_argument,
    input  logic             end_of_message,
    input  logic             interpret_escapes,
    input  logic             trailing_newline,
    input  logic             push_ready,
    output logic             push_valid,
    output esd_pkg::bundle_t push_data
);
    import esd_pkg::*;

    logic [1:0] mode_reg, mode_next;
    logic [7:0] oval_reg, oval_next;
    logic [1:0] left_reg, left_next;
    logic       stop_reg, stop_next;
    bundle_t    res;
    logic       accept;

    function automatic bundle_t emit_f(bundle_t r, logic stop, logic [7:0] v);
        bundle_t o;
        o = r;
        if (!stop && r.cnt != CNT_W'(MAX_RESULTS))
        begin
            o.bytes[r.cnt] = v;
            o.cnt          = r.cnt + CNT_W'(1);
        end
        return o;
    endfunction

    function automatic bundle_t flush_f(bundle_t r, logic stop, logic [1:0] m,
                                        logic [7:0] ov);
        bundle_t o;
        o = r;
        if (m == MODE_ESC)
        begin
            o = emit_f(r, stop, CH_BACKSLASH);
        end
        else if (m == MODE_OCT)
        begin
            o = emit_f(r, stop, ov);
        end
        return o;
    endfunction

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;

    always_comb
    begin
        mode_next = mode_reg;
        oval_next = oval_reg;
        left_next = left_reg;
        stop_next = stop_reg;
        res       = '0;

        if (has_byte)
        begin
            if (!interpret_escapes)
            begin
                res       = flush_f(res, stop_next, mode_next, oval_next);
                mode_next = MODE_PLAIN;
                oval_next = '0;
                left_next = '0;
                res       = emit_f(res, stop_next, text_byte);
            end
            else if (mode_next == MODE_ESC)
            begin
                mode_next = MODE_PLAIN;
                case (text_byte)
                    CH_A:         res = emit_f(res, stop_next, CODE_BEL);
                    CH_B:         res = emit_f(res, stop_next, CODE_BS);
                    CH_C:         stop_next = 1'b1;
                    CH_E:         res = emit_f(res, stop_next, CODE_ESC);
                    CH_F:         res = emit_f(res, stop_next, CODE_FF);
                    CH_N:         res = emit_f(res, stop_next, CH_NEWLINE);
                    CH_R:         res = emit_f(res, stop_next, CODE_CR);
                    CH_T:         res = emit_f(res, stop_next, CODE_TAB);
                    CH_V:         res = emit_f(res, stop_next, CODE_VT);
                    CH_BACKSLASH: res = emit_f(res, stop_next, CH_BACKSLASH);
                    CH_ZERO:
                    begin
                        mode_next = MODE_OCT;
                        oval_next = '0;
                        left_next = 2'd3;
                    end
                    CH_ONE, CH_TWO, CH_THREE, CH_FOUR, CH_FIVE, CH_SIX, CH_SEVEN:
                    begin
                        mode_next = MODE_OCT;
                        oval_next = {5'b0, text_byte[2:0]};
                        left_next = 2'd2;
                    end
                    default:
                    begin
                        res = emit_f(res, stop_next, CH_BACKSLASH);
                        res = emit_f(res, stop_next, text_byte);
                    end
                endcase
            end
            else if (mode_next == MODE_OCT)
            begin
                if (text_byte[7:3] == CH_ZERO[7:3] && left_next != 2'd0)
                begin
                    oval_next = {oval_next[4:0], text_byte[2:0]};
                    left_next = left_next - 2'd1;
                    if (left_next == 2'd0)
                    begin
                        res       = emit_f(res, stop_next, oval_next);
                        mode_next = MODE_PLAIN;
                        oval_next = '0;
                    end
                end
                else
                begin
                    res       = flush_f(res, stop_next, mode_next, oval_next);
                    mode_next = MODE_PLAIN;
                    oval_next = '0;
                    left_next = '0;
                    if (text_byte == CH_BACKSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        res = emit_f(res, stop_next, text_byte);
                    end
                end
            end
            else
            begin
                if (text_byte == CH_BACKSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    res = emit_f(res, stop_next, text_byte);
                end
            end
        end

        if (end_of_argument)
        begin
            res       = flush_f(res, stop_next, mode_next, oval_next);
            mode_next = MODE_PLAIN;
            oval_next = '0;
            left_next = '0;
            if (end_of_message)
            begin
                if (trailing_newline)
                begin
                    res = emit_f(res, stop_next, CH_NEWLINE);
                end
                stop_next = 1'b0;
            end
            else
            begin
                res = emit_f(res, stop_next, CH_SPACE);
            end
        end
    end

    assign push_valid = accept && (res.cnt != '0);
    assign push_data  = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
            oval_reg <= '0;
            left_reg <= '0;
            stop_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            oval_reg <= oval_next;
            left_reg <= left_next;
            stop_reg <= stop_next;
        end
    end

endmodule

// ----- hdl/esd_queue.sv -----
// Short queue of result bundles between the front end and the back end.
module esd_queue
#(
    parameter int unsigned DEPTH = esd_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  esd_pkg::bundle_t push_data,
    output logic             pop_valid,
    input  logic             pop,
    output esd_pkg::bundle_t pop_data
);
    import esd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(DEPTH + 1);

    bundle_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = fill_reg != FILL_W'(DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/esd_back.sv -----
// Back end: sends the bytes of each bundle out one transaction at a time.
module esd_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop,
    input  esd_pkg::bundle_t pop_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             last_of_run
);
    import esd_pkg::*;

    bundle_t          cur_reg;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic             last;

    assign last        = idx_reg == (cur_reg.cnt - CNT_W'(1));
    assign out_valid   = valid_reg;
    assign out_byte    = cur_reg.bytes[idx_reg];
    assign last_of_run = last;
    assign pop         = pop_valid && (!valid_reg || (out_ready && last));

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (pop)
        begin
            idx_next   = '0;
            valid_next = 1'b1;
        end
        else if (valid_reg && out_ready)
        begin
            if (last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_data;
        end
    end

endmodule

// ----- hdl/escape_sequence_decoder_core.sv -----
// Top level of the escape sequence decoder: register file and front/queue/back assembly.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    text_byte, has_byte, end_of_argument, end_of_message
//   output    out_valid / out_ready  out_byte, last_of_run
//   config    APB (psel, penable)    paddr, pwdata, prdata
//
// An input transaction is decoded in the cycle it is accepted and yields up to three bytes.
// Its first byte passes the bundle queue and the back end register before it is offered.
// The back end sends one byte per cycle while out_ready is high and bundles are waiting.
// One input transaction per cycle is taken while each yields at most one byte and output
// is not stalled. Input stalls only when the bundle queue is full, which multi-byte items or
// a stalled output can cause.
// Reset clears the decoder state and sets the trailing newline option.
module escape_sequence_decoder_core
#(
    parameter int unsigned QueueDepth = esd_pkg::QUEUE_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  text_byte,
    input  logic                        has_byte,
    input  logic                        end_of_argument,
    input  logic                        end_of_message,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_byte,
    output logic                        last_of_run,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [esd_pkg::PADDR_W-1:0] paddr,
    input  logic [esd_pkg::PDATA_W-1:0] pwdata,
    output logic [esd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import esd_pkg::*;

    logic    interpret_reg;
    logic    newline_reg;
    logic    cfg_write;
    logic    push_valid;
    logic    push_ready;
    bundle_t push_data;
    logic    pop_valid;
    logic    pop;
    bundle_t pop_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interpret_reg <= 1'b0;
            newline_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            if (paddr == ADDR_INTERPRET)
            begin
                interpret_reg <= pwdata[0];
            end
            if (paddr == ADDR_NEWLINE)
            begin
                newline_reg <= pwdata[0];
            end
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_INTERPRET: prdata = {{(PDATA_W-1){1'b0}}, interpret_reg};
            ADDR_NEWLINE:   prdata = {{(PDATA_W-1){1'b0}}, newline_reg};
            default:        prdata = '0;
        endcase
    end

    esd_front u_front
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .text_byte         (text_byte),
        .has_byte          (has_byte),
        .end_of_argument   (end_of_argument),
        .end_of_message    (end_of_message),
        .interpret_escapes (interpret_reg),
        .trailing_newline  (newline_reg),
        .push_ready        (push_ready),
        .push_valid        (push_valid),
        .push_data         (push_data)
    );

    esd_queue
    #(
        .DEPTH (QueueDepth)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    esd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop         (pop),
        .pop_data    (pop_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

// ----- hdl/esd_checker.sv -----
// Port-level checker for the escape sequence decoder, bound to the top level.
`include "escape_sequence_decoder_core_assert.svh"

module esd_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [7:0]                  out_byte,
    input logic                        last_of_run,
    input logic                        psel,
    input logic                        pwrite,
    input logic [esd_pkg::PADDR_W-1:0] paddr,
    input logic [esd_pkg::PDATA_W-1:0] prdata,
    input logic                        pready
);
    import esd_pkg::*;

    `ESD_ASSERT_SAME(a_pready_high, 1'b1, pready)
    `ESD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last_of_run))
    `ESD_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !last_of_run, out_valid)
    `ESD_ASSERT_SAME(a_output_has_cause, $rose(out_valid), $past(in_valid && in_ready, 2))
    `ESD_ASSERT_SAME(a_read_one_bit, psel && !pwrite && (paddr == ADDR_INTERPRET || paddr == ADDR_NEWLINE), prdata[PDATA_W-1:1] == '0)

endmodule

bind escape_sequence_decoder_core esd_checker u_esd_checker (.*);

// ----- sim/tb_escape_sequence_decoder_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of escape_sequence_decoder_core with a byte-level decoding predictor.
module tb_escape_sequence_decoder_core;
    import esd_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [1:0] DIGITS_AFTER_ZERO  = 2'd3;
    localparam logic [1:0] DIGITS_AFTER_OTHER = 2'd2;

    typedef struct packed {
        logic [7:0] text;
        logic       has;
        logic       eoa;
        logic       eom;
    } text_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_rec_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         text_byte = '0;
    logic               has_byte = 1'b0;
    logic               end_of_argument = 1'b0;
    logic               end_of_message = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         out_byte;
    logic               last_of_run;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic [1:0] dec_mode = MODE_PLAIN;
    logic [7:0] oct_value = '0;
    logic [1:0] oct_left = '0;
    logic       muted = 1'b0;
    logic       esc_on = 1'b0;
    logic       newline_on = 1'b1;

    logic [7:0] run_bytes[$];
    out_rec_t   expected_bytes[$];
    text_item_t pending_items[$];
    text_item_t drv_item;
    out_rec_t   want;

    int errors = 0;
    int in_idle_pct = 33;
    int out_idle_pct = 33;
    int stall_cycles = 0;

    escape_sequence_decoder_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .text_byte       (text_byte),
        .has_byte        (has_byte),
        .end_of_argument (end_of_argument),
        .end_of_message  (end_of_message),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .last_of_run     (last_of_run),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic void emit_byte(input logic [7:0] v);
        if (!muted && run_bytes.size() < MAX_RESULTS)
            run_bytes.push_back(v);
    endfunction

    function automatic void flush_escape();
        if (dec_mode == MODE_ESC)
            emit_byte(CH_BACKSLASH);
        else if (dec_mode == MODE_OCT)
            emit_byte(oct_value);
        dec_mode = MODE_PLAIN;
        oct_value = '0;
        oct_left = '0;
    endfunction

    function automatic void plain_char(input logic [7:0] b);
        if (b == CH_BACKSLASH)
            dec_mode = MODE_ESC;
        else
            emit_byte(b);
    endfunction

    function automatic void escaped_char(input logic [7:0] b);
        dec_mode = MODE_PLAIN;
        case (b)
            CH_A: emit_byte(CODE_BEL);
            CH_B: emit_byte(CODE_BS);
            CH_C: muted = 1'b1;
            CH_E: emit_byte(CODE_ESC);
            CH_F: emit_byte(CODE_FF);
            CH_N: emit_byte(CH_NEWLINE);
            CH_R: emit_byte(CODE_CR);
            CH_T: emit_byte(CODE_TAB);
            CH_V: emit_byte(CODE_VT);
            CH_BACKSLASH: emit_byte(CH_BACKSLASH);
            CH_ZERO:
            begin
                dec_mode = MODE_OCT;
                oct_value = '0;
                oct_left = DIGITS_AFTER_ZERO;
            end
            CH_ONE, CH_TWO, CH_THREE, CH_FOUR, CH_FIVE, CH_SIX, CH_SEVEN:
            begin
                dec_mode = MODE_OCT;
                oct_value = b - CH_ZERO;
                oct_left = DIGITS_AFTER_OTHER;
            end
            default:
            begin
                emit_byte(CH_BACKSLASH);
                emit_byte(b);
            end
        endcase
    endfunction

    function automatic void octal_char(input logic [7:0] b);
        if (b >= CH_ZERO && b <= CH_SEVEN && oct_left != 0)
        begin
            oct_value = 8'(oct_value * 8 + (b - CH_ZERO));
            oct_left = oct_left - 1'b1;
            if (oct_left == 0)
                flush_escape();
        end
        else
        begin
            flush_escape();
            plain_char(b);
        end
    endfunction

    function automatic void decode_item(input text_item_t it);
        run_bytes.delete();
        if (it.has)
        begin
            if (!esc_on)
            begin
                flush_escape();
                emit_byte(it.text);
            end
            else if (dec_mode == MODE_ESC)
                escaped_char(it.text);
            else if (dec_mode == MODE_OCT)
                octal_char(it.text);
            else
                plain_char(it.text);
        end
        if (it.eoa)
        begin
            flush_escape();
            if (it.eom)
            begin
                if (newline_on)
                    emit_byte(CH_NEWLINE);
                muted = 1'b0;
            end
            else
                emit_byte(CH_SPACE);
        end
        foreach (run_bytes[k])
            expected_bytes.push_back('{run_bytes[k], k == run_bytes.size() - 1});
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                decode_item('{text_byte, has_byte, end_of_argument, end_of_message});
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= in_idle_pct)
                begin
                    drv_item = pending_items.pop_front();
                    text_byte <= drv_item.text;
                    has_byte <= drv_item.has;
                    end_of_argument <= drv_item.eoa;
                    end_of_message <= drv_item.eom;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= ($urandom_range(99) >= out_idle_pct);
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                    report_error($sformatf("unexpected byte 0x%02h", out_byte));
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.data)
                        report_error($sformatf("out_byte 0x%02h, expected 0x%02h",
                                               out_byte, want.data));
                    if (last_of_run !== want.last)
                        report_error($sformatf("last_of_run %b, expected %b",
                                               last_of_run, want.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("** escape_sequence_decoder_core: FAILED **");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_item(input logic [7:0] b, input logic has, input logic eoa,
                             input logic eom);
        pending_items.push_back('{b, has, eoa, eom});
    endtask

    task automatic push_bytes(input logic [7:0] bytes[$], input logic close,
                              input logic last_msg);
        if (bytes.size() == 0)
            push_item(8'($urandom_range(255)), 1'b0, close, last_msg);
        else
            foreach (bytes[i])
                push_item(bytes[i], 1'b1, close && (i == bytes.size() - 1),
                          last_msg && close && (i == bytes.size() - 1));
    endtask

    task automatic push_text(input string s, input logic close, input logic last_msg);
        logic [7:0] q[$];
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        push_bytes(q, close, last_msg);
    endtask

    task automatic add_random_items(input int count);
        logic [7:0] arg[$];
        logic [7:0] ch;
        logic       has;
        logic       eoa;
        logic       eom;
        int         made;
        int         n_args;
        int         n_tok;
        int         kind;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(99) < 10)
            begin
                has = $urandom_range(1);
                eoa = $urandom_range(1);
                eom = $urandom_range(1);
                push_item(8'($urandom_range(255)), has, eoa, eom);
                if (has || eoa)
                    made++;
            end
            else
            begin
                n_args = $urandom_range(1, 4);
                for (int a = 0; a < n_args; a++)
                begin
                    arg.delete();
                    n_tok = $urandom_range(0, 5);
                    repeat (n_tok)
                    begin
                        kind = $urandom_range(99);
                        if (kind < 30)
                        begin
                            ch = 8'($urandom_range(8'h20, 8'h7E));
                            arg.push_back(ch == CH_BACKSLASH ? CH_SPACE : ch);
                        end
                        else if (kind < 40)
                            arg.push_back(8'($urandom_range(255)));
                        else if (kind < 62)
                        begin
                            case ($urandom_range(8))
                                0: ch = CH_A;
                                1: ch = CH_B;
                                2: ch = CH_E;
                                3: ch = CH_F;
                                4: ch = CH_N;
                                5: ch = CH_R;
                                6: ch = CH_T;
                                7: ch = CH_V;
                                default: ch = CH_BACKSLASH;
                            endcase
                            arg.push_back(CH_BACKSLASH);
                            arg.push_back(ch);
                        end
                        else if (kind < 80)
                        begin
                            arg.push_back(CH_BACKSLASH);
                            repeat ($urandom_range(1, 5))
                                arg.push_back(8'($urandom_range(CH_ZERO, CH_SEVEN)));
                        end
                        else if (kind < 90)
                        begin
                            arg.push_back(CH_BACKSLASH);
                            arg.push_back(8'($urandom_range(255)));
                        end
                        else if (kind < 94)
                        begin
                            arg.push_back(CH_BACKSLASH);
                            arg.push_back(CH_C);
                        end
                        else
                            arg.push_back(CH_BACKSLASH);
                    end
                    push_bytes(arg, 1'b1, a == n_args - 1);
                    made += (arg.size() == 0) ? 1 : arg.size();
                end
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic interp, input logic nl);
        wait_drained();
        apb_write(ADDR_INTERPRET, PDATA_W'(interp));
        esc_on = interp;
        apb_write(ADDR_NEWLINE, PDATA_W'(nl));
        newline_on = nl;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        push_item(8'h00, 1'b1, 1'b0, 1'b0);
        push_item(8'hFF, 1'b1, 1'b1, 1'b1);

        set_config(1'b1, 1'b1);
        push_text("\\\\", 1'b1, 1'b0);
        push_text("\\0101", 1'b0, 1'b0);
        push_text("\\777", 1'b0, 1'b0);
        push_text("\\9", 1'b1, 1'b0);
        push_text("\\18", 1'b0, 1'b0);
        push_text("\\5", 1'b1, 1'b0);
        push_text("x\\", 1'b1, 1'b1);
        push_text("\\ca", 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b1, 1'b1);
        push_item(CH_A, 1'b1, 1'b0, 1'b1);
        push_item(8'h55, 1'b0, 1'b0, 1'b0);
        push_text("\\1", 1'b0, 1'b0);

        set_config(1'b0, 1'b0);
        add_random_items(40);

        set_config(1'b1, 1'b0);
        add_random_items(60);
        push_text("\\", 1'b0, 1'b0);

        set_config(1'b0, 1'b1);
        add_random_items(30);

        set_config(1'b1, 1'b1);
        in_idle_pct = 0;
        out_idle_pct = 0;
        add_random_items(80);
        wait_drained();
        in_idle_pct = 33;
        out_idle_pct = 33;
        add_random_items(90);

        wait_drained();
        if (errors == 0)
            $display("** escape_sequence_decoder_core: PASSED **");
        else
            $display("** escape_sequence_decoder_core: FAILED **");
        $finish;
    end

endmodule
